FILE: rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    localparam int CharW    = 8;
    localparam int LenW     = 4;
    localparam int WordW    = 64;
    localparam int MaxChars = 8;
    localparam int CfgIdxW  = 2;

    typedef logic [CharW-1:0]   char_t;
    typedef logic [LenW-1:0]    len_t;
    typedef logic [WordW-1:0]   word_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    localparam cfg_idx_t CfgPatternBytes = 2'd0;
    localparam cfg_idx_t CfgPatternLen   = 2'd1;
    localparam cfg_idx_t CfgReplaceBytes = 2'd2;
    localparam cfg_idx_t CfgReplaceLen   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/sfr_if.sv
`default_nettype none

interface sfr_in_if;
    logic          valid;
    logic          ready;
    sfr_pkg::char_t in_byte;
    logic          in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
    logic          valid;
    logic          ready;
    sfr_pkg::char_t out_byte;
    logic          out_has_byte;
    logic          out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/stream_find_and_replace.sv
`default_nettype none

// Streaming find-and-replace on a byte string. Each input transaction carries one
// character and a flag on the final one; every non-overlapping occurrence of the
// configured pattern (leftmost first) is replaced by the configured replacement.
// A new character is accepted every cycle as long as each one yields at most one
// output transaction and the output is not stalled; a character that completes a
// match, or the final character, can yield up to eight, and the input is held off
// while they drain from the result buffer, one per cycle unless the output stalls.
// If the final character leaves nothing to emit, a marker transaction with
// out_has_byte low and out_last high ends the string. A pattern length of zero
// passes the text through. Write configuration only while the block is idle; any
// write drops the characters held in the match window.
module stream_find_and_replace #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire sfr_pkg::cfg_idx_t cfg_index,
    input  wire sfr_pkg::word_t    cfg_data,
    sfr_in_if.sink                 in_ch,
    sfr_out_if.source              out_ch
);
    import sfr_pkg::*;

    localparam int Win      = (MAX_PATTERN < MaxChars) ? MAX_PATTERN : MaxChars;
    localparam int RCap     = (MAX_REPLACE < MaxChars) ? MAX_REPLACE : MaxChars;
    localparam int ResDepth = (Win > RCap) ? ((Win > 1) ? Win : 1) : ((RCap > 1) ? RCap : 1);
    localparam int FW       = $clog2(Win + 1);
    localparam int CW       = $clog2(ResDepth + 1);

    word_t pattern_reg;
    len_t  pattern_len_reg;
    word_t replace_reg;
    len_t  replace_len_reg;

    char_t         win_reg  [Win];
    char_t         win_next [Win];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    char_t         res_reg  [ResDepth];
    char_t         res_next [ResDepth];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          marker_reg;
    logic          marker_next;
    logic          last_reg;
    logic          last_next;

    len_t          plen;
    len_t          rlen;
    logic [FW-1:0] plen_f;
    logic [FW-1:0] fill_eff;
    logic [FW-1:0] fill_new;
    char_t         wnew [Win];
    logic          full;
    logic          same;
    logic          pass;
    logic          accept;
    logic          pop;

    // effective lengths, clipped to what the hardware holds
    assign plen   = (pattern_len_reg > len_t'(Win)) ? len_t'(Win) : pattern_len_reg;
    assign rlen   = (replace_len_reg > len_t'(RCap)) ? len_t'(RCap) : replace_len_reg;
    assign plen_f = FW'(plen);
    assign pass   = (plen == '0);

    assign pop          = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (count_reg == '0) || ((count_reg == CW'(1)) && out_ch.ready);
    assign accept       = in_ch.valid && in_ch.ready;

    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.out_byte     = res_reg[0];
    assign out_ch.out_has_byte = !marker_reg;
    assign out_ch.out_last     = last_reg && (count_reg == CW'(1));

    assign fill_eff = (fill_reg >= plen_f) ? '0 : fill_reg;
    assign fill_new = fill_eff + FW'(1);
    assign full     = (fill_new == plen_f);

    always_comb
    begin
        for (int i = 0; i < Win; i++)
        begin
            wnew[i] = (FW'(i) == fill_eff) ? in_ch.in_byte : win_reg[i];
        end
    end

    // parallel window compare
    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < Win; i++)
        begin
            if ((len_t'(i) < plen) && (wnew[i] != pattern_reg[CharW*i +: CharW]))
            begin
                same = 1'b0;
            end
        end
    end

    // window update
    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept && !pass)
        begin
            win_next  = wnew;
            fill_next = fill_new;
            if (full)
            begin
                if (same)
                begin
                    fill_next = '0;
                end
                else
                begin
                    for (int i = 0; i < Win - 1; i++)
                    begin
                        win_next[i] = wnew[i + 1];
                    end
                    fill_next = plen_f - FW'(1);
                end
            end
            if (in_ch.in_last)
            begin
                fill_next = '0;
            end
        end
        if (cfg_wr_en)
        begin
            fill_next = '0;
        end
    end

    // result buffer: load on accept, shift on each output transaction
    always_comb
    begin
        res_next    = res_reg;
        count_next  = count_reg;
        marker_next = marker_reg;
        last_next   = last_reg;
        if (pop)
        begin
            for (int k = 0; k < ResDepth - 1; k++)
            begin
                res_next[k] = res_reg[k + 1];
            end
            res_next[ResDepth-1] = '0;
            count_next = count_reg - CW'(1);
        end
        if (accept)
        begin
            marker_next = 1'b0;
            last_next   = in_ch.in_last;
            for (int k = 0; k < ResDepth; k++)
            begin
                res_next[k] = '0;
            end
            if (pass)
            begin
                res_next[0] = in_ch.in_byte;
                count_next  = CW'(1);
            end
            else if (full && same)
            begin
                for (int k = 0; k < ResDepth; k++)
                begin
                    if (k < RCap)
                    begin
                        res_next[k] = replace_reg[CharW*k +: CharW];
                    end
                end
                count_next = CW'(rlen);
            end
            else
            begin
                for (int k = 0; k < ResDepth; k++)
                begin
                    if (k < Win)
                    begin
                        res_next[k] = wnew[k];
                    end
                end
                if (in_ch.in_last)
                begin
                    count_next = CW'(fill_new);
                end
                else if (full)
                begin
                    count_next = CW'(1);
                end
                else
                begin
                    count_next = '0;
                end
            end
            if (in_ch.in_last && (count_next == '0))
            begin
                res_next[0] = '0;
                count_next  = CW'(1);
                marker_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= '0;
            replace_reg     <= '0;
            replace_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CfgPatternBytes: pattern_reg     <= cfg_data;
                CfgPatternLen:   pattern_len_reg <= cfg_data[LenW-1:0];
                CfgReplaceBytes: replace_reg     <= cfg_data;
                CfgReplaceLen:   replace_len_reg <= cfg_data[LenW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            count_reg  <= '0;
            marker_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            marker_reg <= marker_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sfr_checker.sv
`default_nettype none

module sfr_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire sfr_pkg::char_t out_byte,
    input wire logic           out_has_byte,
    input wire logic           out_last
);
    // a stalled output transaction stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    // a stalled output transaction keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_byte) && $stable(out_has_byte) && $stable(out_last))
        else $error("output payload changed while stalled");

    // an end marker only closes a string
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_has_byte |-> out_last)
        else $error("end marker without last flag");

    // no new input while a result is stuck
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while output stalled");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_has_byte (out_ch.out_has_byte),
    .out_last     (out_ch.out_last)
);

`default_nettype wire
